/* design/gbia_pkg.sv */
// Package for the grouped bitmap inode allocator: command and status codes.
// No dependencies.
`default_nettype none
package gbia_pkg;
  localparam int CMD_W = 2;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_WBYTE = 2'd1;
  localparam logic [1:0] CMD_GCNT  = 2'd2;
  localparam logic [1:0] CMD_TOTAL = 2'd3;
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOTAL0   = 3'd1;
  localparam logic [2:0] ST_NOGROUP  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_LOADDONE = 3'd4;
  localparam int SLOT_W = 17;
  localparam int GCNT_W = 13;
  localparam logic [12:0] GCNT_MAX = 13'd8191;
  localparam logic [7:0] BYTE_FULL = 8'hFF;
endpackage
`default_nettype wire

/* design/gbia_in_if.sv */
// Input channel interface of the allocator: valid/ready plus command fields.
// No dependencies.
`default_nettype none
interface gbia_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [16:0] parent_inode;
  logic [3:0]  group_index;
  logic [8:0]  byte_index;
  logic [16:0] load_value;
  modport source (output valid, command, parent_inode, group_index, byte_index,
                  load_value, input ready);
  modport sink (input valid, command, parent_inode, group_index, byte_index,
                load_value, output ready);
endinterface
`default_nettype wire

/* design/gbia_out_if.sv */
// Result channel interface of the allocator: valid/ready plus result fields.
// No dependencies.
`default_nettype none
interface gbia_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] inode_number;
  logic [2:0]  status;
  modport source (output valid, inode_number, status, input ready);
  modport sink (input valid, inode_number, status, output ready);
endinterface
`default_nettype wire

/* design/grouped_bitmap_inode_allocator.sv */
// Grouped bitmap inode allocator, top level.
// Depends on gbia_pkg, gbia_in_if and gbia_out_if.
//
//  channel | direction | beat contents
//  in_     | sink      | command, parent_inode, group_index, byte_index, load_value
//  out_    | source    | inode_number, status
//  cfg_    | write     | cfg_index selects inodes_per_group (0) or group_count (1)
//
// An allocation first finds the start group with a shift-subtract divide by the
// group size, then walks the groups and reads the bitmap bytes of the chosen
// group one at a time from the bitmap RAM. One item is in flight at a time;
// the block is not ready until its result beat has been taken. Reset is synchronous.
`default_nettype none
module grouped_bitmap_inode_allocator #(
  parameter int MAX_GROUPS = 16,
  parameter int MAX_SLOTS_PER_GROUP = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  gbia_in_if.sink   in_ch,
  gbia_out_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  import gbia_pkg::*;

  localparam int BPG   = MAX_SLOTS_PER_GROUP / 8;
  localparam int BW    = (BPG > 1) ? $clog2(BPG) : 1;
  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int DEPTH = MAX_GROUPS * BPG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IPGMAX = (MAX_SLOTS_PER_GROUP > 8191) ? 8184 : (MAX_SLOTS_PER_GROUP & ~7);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SCAN_UP, S_SCAN_WRAP, S_RD, S_CHK, S_WR, S_MUL, S_OUT
  } state_t;

  state_t state_r;
  logic [12:0] ipg_cfg_r;
  logic [4:0]  gc_cfg_r;
  logic [12:0] gfree_r [MAX_GROUPS];
  logic [16:0] total_r;
  logic [7:0]  mem [DEPTH];
  logic [7:0]  rd_r;
  logic [16:0] quot_r, rem_r;
  logic [4:0]  dcnt_r;
  logic [8:0]  g_r;       // wide enough for groups up to 256 plus one
  logic [8:0]  start_r;
  logic [BW:0] byte_r;
  logic [2:0]  bit_r;
  logic [16:0] acc_r;
  logic [16:0] res_num_r;
  logic [2:0]  res_st_r;
  logic        out_valid_r;

  // Effective configuration, clamped as the register contract requires.
  logic [12:0] ipg;
  logic [8:0]  gc;
  logic [13:0] nbytes;
  always_comb begin
    ipg = {ipg_cfg_r[12:3], 3'b000};
    if (ipg < 13'd8) ipg = 13'd8;
    if (32'(ipg) > IPGMAX) ipg = 13'(IPGMAX);
    gc = (gc_cfg_r == 5'd0) ? 9'd1 : 9'(gc_cfg_r);
    if (32'(gc) > MAX_GROUPS) gc = 9'(MAX_GROUPS);
    nbytes = 14'(ipg[12:3]);
  end

  logic [GW-1:0] gsel;
  assign gsel = g_r[GW-1:0];
  logic [AW-1:0] addr;
  assign addr = AW'(32'(gsel) * BPG + 32'(byte_r[BW-1:0]));

  logic [17:0] trial;
  assign trial = {rem_r, quot_r[16]} - {5'd0, ipg};

  logic [2:0] first_zero;
  always_comb begin
    first_zero = 3'd0;
    for (int i = 7; i >= 0; i--) if (!rd_r[i]) first_zero = 3'(i);
  end

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.inode_number = res_num_r;
  assign out_ch.status = res_st_r;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  logic [16:0] par1;
  assign par1 = (in_ch.parent_inode == 17'd0) ? 17'd0 : in_ch.parent_inode - 17'd1;

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.command == CMD_WBYTE && 32'(in_ch.group_index) < MAX_GROUPS
        && 32'(in_ch.byte_index) < BPG)
      mem[AW'(32'(in_ch.group_index) * BPG + 32'(in_ch.byte_index))] <= in_ch.load_value[7:0];
    else if (state_r == S_WR)
      mem[addr] <= rd_r | (8'd1 << bit_r);
    if (state_r == S_RD) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      ipg_cfg_r <= 13'd4096;
      gc_cfg_r <= 5'd16;
      total_r <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) gfree_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) gc_cfg_r <= cfg_data[4:0];
        else ipg_cfg_r <= cfg_data;
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_num_r <= '0;
            res_st_r <= (in_ch.command == CMD_ALLOC && total_r == 17'd0) ? ST_TOTAL0 :
                        ST_LOADDONE;
            state_r <= (in_ch.command == CMD_ALLOC && total_r != 17'd0) ? S_DIV : S_OUT;
            case (in_ch.command)
              CMD_ALLOC: begin
                if (total_r != 17'd0) begin
                  quot_r <= par1; rem_r <= '0; dcnt_r <= '0;
                end
              end
              CMD_GCNT: if (32'(in_ch.group_index) < MAX_GROUPS)
                gfree_r[in_ch.group_index] <= (in_ch.load_value > 17'(GCNT_MAX)) ?
                                              GCNT_MAX : in_ch.load_value[12:0];
              CMD_TOTAL: total_r <= in_ch.load_value;
              default: ;
            endcase
          end
        end
        S_DIV: begin
          // Restoring divide, one quotient bit per cycle.
          if (!trial[17]) rem_r <= trial[16:0];
          else rem_r <= {rem_r[15:0], quot_r[16]};
          quot_r <= {quot_r[15:0], !trial[17]};
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd16) begin
            start_r <= (|quot_r[15:8] || {quot_r[7:0], !trial[17]} > 9'd256) ? 9'd256 :
                       9'({quot_r[7:0], !trial[17]});
            g_r <= (|quot_r[15:8]) ? 9'd256 : 9'({quot_r[7:0], !trial[17]});
            state_r <= S_SCAN_UP;
          end
        end
        S_SCAN_UP: begin
          if (g_r >= gc) begin
            g_r <= '0;
            state_r <= S_SCAN_WRAP;
          end else if (gfree_r[gsel] != 13'd0) begin
            byte_r <= '0; state_r <= S_RD;
          end else g_r <= g_r + 9'd1;
        end
        S_SCAN_WRAP: begin
          if (g_r >= start_r || g_r >= gc) begin
            res_st_r <= ST_NOGROUP; state_r <= S_OUT;
          end else if (gfree_r[gsel] != 13'd0) begin
            byte_r <= '0; state_r <= S_RD;
          end else g_r <= g_r + 9'd1;
        end
        S_RD: begin
          if (14'(byte_r) >= nbytes || 32'(byte_r) >= BPG) begin
            res_st_r <= ST_FULL; state_r <= S_OUT;
          end else state_r <= S_CHK;
        end
        S_CHK: begin
          if (rd_r == BYTE_FULL) begin
            byte_r <= byte_r + 1'b1; state_r <= S_RD;
          end else begin
            bit_r <= first_zero; state_r <= S_WR;
          end
        end
        S_WR: begin
          gfree_r[gsel] <= gfree_r[gsel] - 13'd1;
          total_r <= total_r - 17'd1;
          acc_r <= 17'(32'(byte_r) * 8 + 32'(bit_r) + 1);
          state_r <= S_MUL;
        end
        S_MUL: begin
          res_num_r <= 17'(32'(gsel) * 32'(ipg)) + acc_r;
          res_st_r <= ST_OK;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_valid_r) else $error("ready while result pending");
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_st_r == ST_OK) |-> res_num_r != 17'd0)
    else $error("allocated slot zero");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_st_r != ST_OK) |-> res_num_r == 17'd0)
    else $error("failure carries a slot");
endmodule
`default_nettype wire

/* tb/grouped_bitmap_inode_allocator_tb.sv */
// Self-checking testbench for grouped_bitmap_inode_allocator: directed and random beats,
// with results checked against an in-bench prediction of the allocator.
// Depends on gbia_pkg, gbia_in_if, gbia_out_if and the allocator RTL.
`timescale 1ns / 100ps

module grouped_bitmap_inode_allocator_tb;
  import gbia_pkg::*;

  localparam int NGROUPS = 16;
  localparam int SLOTS_MAX = 4096;
  localparam int GRP_BYTES = SLOTS_MAX / 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] parent_inode;
    logic [3:0]  group_index;
    logic [8:0]  byte_index;
    logic [16:0] load_value;
  } beat_t;

  typedef struct packed {
    logic [16:0] inode_number;
    logic [2:0]  status;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  gbia_in_if in_ch ();
  gbia_out_if out_ch ();

  grouped_bitmap_inode_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predicted state of the allocator.
  logic [7:0]  bitmap_copy [SLOTS_MAX * NGROUPS / 8];
  bit          byte_known [SLOTS_MAX * NGROUPS / 8];
  logic [12:0] free_per_group [NGROUPS];
  logic [16:0] free_total;
  logic [12:0] slots_per_group_reg;
  logic [4:0]  groups_in_use_reg;

  alloc_result_t expected_results[$];
  int error_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int idle_cycles = 0;
  int status_seen [8];
  int beats_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ALLOC;
    in_ch.parent_inode = '0;
    in_ch.group_index = '0;
    in_ch.byte_index = '0;
    in_ch.load_value = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int eff_slots();
    int v;
    v = slots_per_group_reg & ~13'd7;
    if (v < 8) v = 8;
    if (v > SLOTS_MAX) v = SLOTS_MAX;
    return v;
  endfunction

  function automatic int eff_groups();
    int v;
    v = groups_in_use_reg;
    if (v < 1) v = 1;
    if (v > NGROUPS) v = NGROUPS;
    return v;
  endfunction

  // Group that an allocation would search, or -1 when none has a free count.
  function automatic int pick_group(input logic [16:0] parent);
    int start;
    int p;
    p = (parent == 0) ? 1 : parent;
    start = (p - 1) / eff_slots();
    for (int g = start; g < eff_groups(); g++)
      if (free_per_group[g] != 0) return g;
    for (int g = 0; g < start && g < eff_groups(); g++)
      if (free_per_group[g] != 0) return g;
    return -1;
  endfunction

  // First bitmap byte the allocation would read before it was ever written, or -1.
  function automatic int first_unknown_byte(input logic [16:0] parent);
    int g;
    int idx;
    if (free_total == 0) return -1;
    g = pick_group(parent);
    if (g < 0) return -1;
    for (int b = 0; b < eff_slots() / 8; b++) begin
      idx = g * GRP_BYTES + b;
      if (!byte_known[idx]) return idx;
      if (bitmap_copy[idx] != BYTE_FULL) return -1;
    end
    return -1;
  endfunction

  function automatic alloc_result_t predict_allocation(input logic [16:0] parent);
    alloc_result_t r;
    int g;
    int idx;
    int bitpos;
    r.inode_number = '0;
    if (free_total == 0) begin
      r.status = ST_TOTAL0;
      return r;
    end
    g = pick_group(parent);
    if (g < 0) begin
      r.status = ST_NOGROUP;
      return r;
    end
    for (int b = 0; b < eff_slots() / 8; b++) begin
      idx = g * GRP_BYTES + b;
      if (bitmap_copy[idx] != BYTE_FULL) begin
        bitpos = 0;
        while (bitmap_copy[idx][bitpos]) bitpos++;
        bitmap_copy[idx][bitpos] = 1'b1;
        free_per_group[g] = free_per_group[g] - 1'b1;
        free_total = free_total - 1'b1;
        r.inode_number = 17'(g * eff_slots() + b * 8 + bitpos + 1);
        r.status = ST_OK;
        return r;
      end
    end
    r.status = ST_FULL;
    return r;
  endfunction

  function automatic alloc_result_t predict_beat(input beat_t b);
    alloc_result_t r;
    int idx;
    r.inode_number = '0;
    r.status = ST_LOADDONE;
    case (b.command)
      CMD_ALLOC: r = predict_allocation(b.parent_inode);
      CMD_WBYTE: begin
        idx = b.group_index * GRP_BYTES + b.byte_index;
        bitmap_copy[idx] = b.load_value[7:0];
        byte_known[idx] = 1'b1;
      end
      CMD_GCNT: free_per_group[b.group_index] =
          (b.load_value > GCNT_MAX) ? GCNT_MAX : b.load_value[12:0];
      default: free_total = b.load_value;
    endcase
    return r;
  endfunction

  task automatic send_beat(input beat_t b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = b.command;
    in_ch.parent_inode = b.parent_inode;
    in_ch.group_index = b.group_index;
    in_ch.byte_index = b.byte_index;
    in_ch.load_value = b.load_value;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_beat(b));
    beats_sent++;
  endtask

  function automatic beat_t random_beat(input logic [1:0] cmd);
    beat_t b;
    b.command = cmd;
    b.parent_inode = 17'($urandom);
    b.group_index = 4'($urandom);
    b.byte_index = 9'($urandom);
    b.load_value = 17'($urandom);
    return b;
  endfunction

  task automatic load(input logic [1:0] cmd, input int grp, input int byt, input int val);
    beat_t b;
    b = random_beat(cmd);
    b.group_index = 4'(grp);
    b.byte_index = 9'(byt);
    b.load_value = 17'(val);
    send_beat(b);
  endtask

  // Writes any bitmap byte the search would reach unwritten, then allocates.
  task automatic allocate(input logic [16:0] parent);
    beat_t b;
    int idx;
    idx = first_unknown_byte(parent);
    while (idx >= 0) begin
      load(CMD_WBYTE, idx / GRP_BYTES, idx % GRP_BYTES,
           ($urandom_range(99) < 55) ? 8'hFF : $urandom_range(255));
      idx = first_unknown_byte(parent);
    end
    b = random_beat(CMD_ALLOC);
    b.parent_inode = parent;
    send_beat(b);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_config(input int slots, input int groups);
    drain();
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = 1'b0;
    cfg_data = 13'(slots);
    @(negedge clk);
    cfg_index = 1'b1;
    cfg_data = 13'(groups);
    @(negedge clk);
    cfg_we = 1'b0;
    slots_per_group_reg = 13'(slots);
    groups_in_use_reg = 5'(groups);
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with no beat accepted", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat inode %0d status %0d", $time,
                 out_ch.inode_number, out_ch.status);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        status_seen[exp_r.status]++;
        if (out_ch.inode_number !== exp_r.inode_number)
          begin
            $display("%0t: inode_number expected %0d actual %0d", $time,
                     exp_r.inode_number, out_ch.inode_number);
            error_count++;
          end
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    // Total count is zero after reset, so nothing can be allocated.
    allocate(17'd1);
    load(CMD_TOTAL, 0, 0, 10);
    allocate(17'd5);
  endtask

  task automatic test_small_groups();
    write_config(8, 2);
    load(CMD_WBYTE, 0, 0, 8'hFE);
    load(CMD_GCNT, 0, 0, 2);
    allocate(17'd0);
    allocate(17'd9);
    // Full bitmap in the chosen group.
    load(CMD_WBYTE, 1, 0, 8'hFF);
    load(CMD_GCNT, 1, 0, 1);
    load(CMD_GCNT, 0, 0, 0);
    allocate(17'd9);
    // Start group beyond the groups in use wraps to group 0.
    load(CMD_GCNT, 0, 0, 3);
    allocate(17'h1FFFF);
    load(CMD_GCNT, 2, 0, 17'h1FFFF);
    load(CMD_TOTAL, 0, 0, 17'h1FFFF);
    load(CMD_WBYTE, 15, 511, 8'h00);
  endtask

  task automatic test_config_extremes();
    write_config(13, 0);
    allocate(17'd3);
    write_config(0, 31);
    allocate(17'd20);
    write_config(13'h1FFF, 16);
    load(CMD_GCNT, 15, 0, 5);
    allocate(17'd65536);
    allocate(17'd61441);
  endtask

  task automatic random_phase(input int n, input int src, input int snk, input int slots,
                              input int groups, input bit hold_off);
    int r;
    write_config(slots, groups);
    src_idle_pct = src;
    snk_idle_pct = snk;
    load(CMD_TOTAL, 0, 0, ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(400));
    for (int g = 0; g < NGROUPS; g++)
      if ($urandom_range(2) != 0) load(CMD_GCNT, g, 0, $urandom_range(12));
    for (int k = 0; k < n; k++) begin
      if (hold_off && k == n / 2) drain();
      r = $urandom_range(99);
      if (r < 62) begin
        if ($urandom_range(4) == 0) allocate(17'($urandom));
        else allocate(17'($urandom_range(1, eff_slots() * eff_groups())));
      end else if (r < 78) begin
        load(CMD_WBYTE, $urandom_range(15), $urandom_range(511),
             ($urandom_range(1) == 0) ? 8'hFF : $urandom_range(255));
      end else if (r < 92) begin
        load(CMD_GCNT, $urandom_range(15), 0,
             ($urandom_range(7) == 0) ? $urandom : $urandom_range(12));
      end else begin
        load(CMD_TOTAL, 0, 0, ($urandom_range(5) == 0) ? $urandom : $urandom_range(60));
      end
    end
  endtask

  task automatic test_random_traffic();
    random_phase(90, 0, 0, 8, 1, 1'b0);
    random_phase(90, 68, 0, 16, 3, 1'b1);
    random_phase(90, 0, 68, 4096, 16, 1'b0);
    random_phase(90, 36, 36, 64, 31, 1'b0);
    random_phase(90, 0, 0, 13'h1FFF, 16, 1'b0);
    random_phase(90, 68, 0, 0, 0, 1'b0);
    random_phase(90, 0, 68, 8 * $urandom_range(1, 64), $urandom_range(1, 16), 1'b0);
    random_phase(90, 36, 36, 24, 5, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < SLOTS_MAX * NGROUPS / 8; i++) begin
      bitmap_copy[i] = '0;
      byte_known[i] = 1'b0;
    end
    for (int g = 0; g < NGROUPS; g++) free_per_group[g] = '0;
    free_total = '0;
    slots_per_group_reg = 13'd4096;
    groups_in_use_reg = 5'd16;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_small_groups();
    test_config_extremes();
    test_random_traffic();

    drain();
    repeat (1200) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    $display("Sent %0d beats over twelve configuration writes and four idling patterns.",
             beats_sent);
    $display("Results: %0d allocated, %0d total zero, %0d no group, %0d full, %0d loads.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
